// ===== rtl/ircfs_pkg.sv =====
// Package for the chat text code stripper: parser phases, queue entry type,
// character constants and classification helpers. No dependencies.
package ircfs_pkg;

  typedef enum logic [2:0] {
    PH_NORMAL = 3'd0,
    PH_CODE   = 3'd1,
    PH_FG1    = 3'd2,
    PH_FG2    = 3'd3,
    PH_COMMA  = 3'd4,
    PH_BG1    = 3'd5
  } phase_t;

  // One queued action: an optional leading comma, then the main byte.
  typedef struct packed {
    logic       lead;
    logic [7:0] main;
  } op_t;

  localparam int unsigned QDEPTH = 4;

  localparam logic [7:0] CH_COLOUR  = 8'h03;
  localparam logic [7:0] CH_BOLD    = 8'h02;
  localparam logic [7:0] CH_PLAIN   = 8'h0F;
  localparam logic [7:0] CH_REVERSE = 8'h12;
  localparam logic [7:0] CH_ULINE2  = 8'h15;
  localparam logic [7:0] CH_ULINE   = 8'h1F;
  localparam logic [7:0] CH_MAXTEXT = 8'h7F;
  localparam logic [7:0] CH_COMMA   = 8'h2C;
  localparam logic [7:0] CH_DOT     = 8'h2E;
  localparam logic [7:0] CH_NL      = 8'h0A;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_NINE    = 8'h39;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  function automatic logic is_fmt(input logic [7:0] c);
    return (c == CH_BOLD) || (c == CH_PLAIN) || (c == CH_REVERSE) ||
           (c == CH_ULINE2) || (c == CH_ULINE);
  endfunction

endpackage

// ===== rtl/ircfs_front.sv =====
// Front end: accepts input beats, runs the colour-code parser and pushes
// one action per beat that yields output. Depends on ircfs_pkg.
module ircfs_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_wr_en,
  input  logic             cfg_wr_data,
  input  logic             in_valid,
  input  logic             in_stall,
  input  logic [7:0]       in_char_in,
  input  logic             in_end_of_line,
  output logic             push,
  output ircfs_pkg::op_t   push_op
);
  import ircfs_pkg::*;

  logic   filter_en_r;
  phase_t phase_r, phase_nxt;
  logic   accept;
  logic   plain, lead, emit;
  logic [7:0] emit_b;

  assign accept = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      filter_en_r <= 1'b1;
      phase_r     <= PH_NORMAL;
    end else begin
      if (cfg_wr_en) filter_en_r <= cfg_wr_data;
      if (accept) phase_r <= phase_nxt;
    end
  end

  always_comb begin
    phase_nxt = phase_r;
    plain     = 1'b0;
    lead      = 1'b0;
    emit      = 1'b0;
    emit_b    = in_char_in;
    if (in_end_of_line) begin
      lead      = (phase_r == PH_COMMA);
      emit      = 1'b1;
      emit_b    = CH_NL;
      phase_nxt = PH_NORMAL;
    end else begin
      if (!filter_en_r) begin
        lead      = (phase_r == PH_COMMA);
        phase_nxt = PH_NORMAL;
        plain     = 1'b1;
      end else begin
        case (phase_r)
          PH_CODE: begin
            if (is_digit(in_char_in)) phase_nxt = PH_FG1;
            else begin
              phase_nxt = PH_NORMAL;
              plain     = 1'b1;
            end
          end
          PH_FG1, PH_FG2: begin
            if (phase_r == PH_FG1 && is_digit(in_char_in)) phase_nxt = PH_FG2;
            else if (in_char_in == CH_COMMA) phase_nxt = PH_COMMA;
            else begin
              phase_nxt = PH_NORMAL;
              plain     = 1'b1;
            end
          end
          PH_COMMA: begin
            if (is_digit(in_char_in)) phase_nxt = PH_BG1;
            else begin
              lead      = 1'b1;
              phase_nxt = PH_NORMAL;
              plain     = 1'b1;
            end
          end
          PH_BG1: begin
            phase_nxt = PH_NORMAL;
            plain     = !is_digit(in_char_in);
          end
          default: begin
            phase_nxt = PH_NORMAL;
            plain     = 1'b1;
          end
        endcase
      end
      if (plain) begin
        if (in_char_in > CH_MAXTEXT) begin
          emit   = 1'b1;
          emit_b = CH_DOT;
        end else if (filter_en_r && in_char_in == CH_COLOUR) begin
          phase_nxt = PH_CODE;
        end else if (!(filter_en_r && is_fmt(in_char_in))) begin
          emit = 1'b1;
        end
      end
    end
  end

  // A lone held comma travels as the main byte.
  always_comb begin
    push_op.lead = emit && lead;
    push_op.main = emit ? emit_b : CH_COMMA;
  end

  assign push = accept && (emit || lead);

endmodule

// ===== rtl/ircfs_queue.sv =====
// Short FIFO of parser actions between front and back end.
// Depends on ircfs_pkg.
module ircfs_queue #(
  parameter int unsigned DEPTH = ircfs_pkg::QDEPTH
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  ircfs_pkg::op_t push_op,
  input  logic           pop,
  output ircfs_pkg::op_t head_op,
  output logic           full,
  output logic           empty
);
  import ircfs_pkg::*;

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] PLAST = PW'(DEPTH - 1);
  localparam logic [CW-1:0] CFULL = CW'(DEPTH);

  op_t           mem_r [DEPTH];
  logic [PW-1:0] wp_r, rp_r;
  logic [CW-1:0] cnt_r;
  logic          do_push, do_pop;

  assign full    = (cnt_r == CFULL);
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head_op = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wp_r] <= push_op;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) wp_r <= (wp_r == PLAST) ? '0 : wp_r + 1'b1;
      if (do_pop)  rp_r <= (rp_r == PLAST) ? '0 : rp_r + 1'b1;
      if (do_push && !do_pop) cnt_r <= cnt_r + 1'b1;
      else if (do_pop && !do_push) cnt_r <= cnt_r - 1'b1;
    end
  end

`ifndef SYNTHESIS
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n) cnt_r <= CFULL)
    else $error("queue count out of range");
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n) !(push && full))
    else $error("push into full queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n) !(pop && empty))
    else $error("pop from empty queue");
`endif

endmodule

// ===== rtl/ircfs_back.sv =====
// Back end: expands queued actions into output beats through an output
// register. Depends on ircfs_pkg.
module ircfs_back (
  input  logic           clk,
  input  logic           rst_n,
  input  ircfs_pkg::op_t head_op,
  input  logic           empty,
  output logic           pop,
  input  logic           out_stall,
  output logic           out_valid,
  output logic [7:0]     out_char_out,
  output logic           out_last_of_run
);
  import ircfs_pkg::*;

  logic       out_valid_r, out_valid_nxt;
  logic [7:0] char_r, char_nxt;
  logic       last_r, last_nxt;
  logic       sent_r, sent_nxt;
  logic       ld;

  assign ld = !out_valid_r || !out_stall;

  always_comb begin
    out_valid_nxt = out_valid_r;
    char_nxt      = char_r;
    last_nxt      = last_r;
    sent_nxt      = sent_r;
    pop           = 1'b0;
    if (ld) begin
      out_valid_nxt = !empty;
      if (!empty) begin
        if (head_op.lead && !sent_r) begin
          char_nxt = CH_COMMA;
          last_nxt = 1'b0;
          sent_nxt = 1'b1;
        end else begin
          char_nxt = head_op.main;
          last_nxt = 1'b1;
          sent_nxt = 1'b0;
          pop      = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      sent_r      <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      sent_r      <= sent_nxt;
    end
  end

  always_ff @(posedge clk) begin
    char_r <= char_nxt;
    last_r <= last_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_char_out    = char_r;
  assign out_last_of_run = last_r;

`ifndef SYNTHESIS
  a_lead_follows: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_stall && !last_r |=> out_valid_r && last_r)
    else $error("held comma not followed by its byte");
  a_sent_only_early: assert property (@(posedge clk) disable iff (!rst_n)
    sent_r |-> out_valid_r && !last_r && char_r == CH_COMMA)
    else $error("comma flag set without a comma beat");
  a_sent_has_head: assert property (@(posedge clk) disable iff (!rst_n)
    sent_r |-> !empty)
    else $error("comma flag set with no queued action");
`endif

endmodule

// ===== rtl/irc_format_code_stripper.sv =====
// Top level of the chat text code stripper: front parser, action queue and
// output back end. Depends on ircfs_pkg, ircfs_front, ircfs_queue, ircfs_back.
//
// Usage:
//   Input channel in_valid/in_stall carries one text byte (in_char_in) or an
//   end-of-line mark (in_end_of_line) per beat. Output channel
//   out_valid/out_stall carries displayable bytes; out_last_of_run marks the
//   final byte caused by one input beat. Input beats that cause nothing
//   (dropped codes and digits) give no output beat.
//   cfg_wr_en/cfg_wr_data writes filter_enable (1 strips colour and format
//   codes); write it only while the block is idle.
//   Each parser action is written into the queue, then loaded into the output register.
//   Throughput: one input beat per cycle while in_stall is low; a beat that
//   releases a held comma along with its own byte yields two output beats, so the output side sets the pace then.
//   The queue of QDEPTH actions lets the parser keep accepting while the
//   receiver stalls; in_stall rises only when the queue is full.
//   Synchronous reset sets filter_enable to 1, the parser to plain text and
//   empties the queue and output register.
module irc_format_code_stripper #(
  parameter int unsigned QDEPTH = ircfs_pkg::QDEPTH
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_wr_en,
  input  logic       cfg_wr_data,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_char_in,
  input  logic       in_end_of_line,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_char_out,
  output logic       out_last_of_run
);
  import ircfs_pkg::*;

  logic push, pop, full, empty;
  op_t  push_op, head_op;

  assign in_stall = full;

  ircfs_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .in_valid       (in_valid),
    .in_stall       (full),
    .in_char_in     (in_char_in),
    .in_end_of_line (in_end_of_line),
    .push           (push),
    .push_op        (push_op)
  );

  ircfs_queue #(.DEPTH(QDEPTH)) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .push_op (push_op),
    .pop     (pop),
    .head_op (head_op),
    .full    (full),
    .empty   (empty)
  );

  ircfs_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .head_op         (head_op),
    .empty           (empty),
    .pop             (pop),
    .out_stall       (out_stall),
    .out_valid       (out_valid),
    .out_char_out    (out_char_out),
    .out_last_of_run (out_last_of_run)
  );

endmodule
